>>> hw/rtl/pbpa_pkg.sv
// pbpa_pkg: constants, types and helper functions of the bitmap page allocator
// used by pbpa_ctrl, pbpa_datapath and partitioned_bitmap_page_allocator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pbpa_pkg;

    // pool and namespace geometry (POOL_PAGES and NS_MAX are powers of two)
    localparam int POOL_PAGES  = 1024;
    localparam int NS_MAX      = 16;
    localparam int WORD_BITS   = 32;
    localparam int PAGE_W      = $clog2(POOL_PAGES);
    localparam int CNT_W       = PAGE_W + 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int WORDS       = POOL_PAGES / WORD_BITS;
    localparam int WADDR_W     = $clog2(WORDS);
    localparam int NS_W        = $clog2(NS_MAX);

    // field and port widths
    localparam int REQ_W       = 2;
    localparam int LOG2_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NS_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NS_COUNT_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC_PAGE = 2'd0,
        REQ_FREE_PAGE  = 2'd1,
        REQ_ALLOC_NS   = 2'd2,
        REQ_FREE_NS    = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_NS,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // request transfer, latch bounds
        logic rd;        // read bitmap word
        logic check;     // examine word, update bitmap
        logic ns_op;     // namespace alloc or free
        logic out_load;  // move result to output register
    } pbpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;       // incoming page alloc has an empty or invalid range
        logic more;      // scan goes on with another word
    } pbpa_sts_t;

    // lowest set bit position
    function automatic logic [BIT_W-1:0] first_set(input word_t v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i])
                pos = BIT_W'(i);
        end
        return pos;
    endfunction

    // bits of word w whose page is at or above bound b
    function automatic word_t mask_at_or_above(input logic [WADDR_W-1:0] w,
                                               input logic [CNT_W-1:0] b);
        logic [CNT_W-BIT_W-1:0] bw;
        logic [CNT_W-BIT_W-1:0] we;
        word_t m;
        bw = b[CNT_W-1:BIT_W];
        we = (CNT_W-BIT_W)'(w);
        if (we > bw)
            m = {WORD_BITS{1'b1}};
        else if (we < bw)
            m = '0;
        else
            m = {WORD_BITS{1'b1}} << b[BIT_W-1:0];
        return m;
    endfunction

    // bits of word w whose page is below bound b
    function automatic word_t mask_below(input logic [WADDR_W-1:0] w,
                                         input logic [CNT_W-1:0] b);
        logic [CNT_W-BIT_W-1:0] bw;
        logic [CNT_W-BIT_W-1:0] we;
        word_t m;
        bw = b[CNT_W-1:BIT_W];
        we = (CNT_W-BIT_W)'(w);
        if (we > bw)
            m = '0;
        else if (we < bw)
            m = {WORD_BITS{1'b1}};
        else
            m = ~({WORD_BITS{1'b1}} << b[BIT_W-1:0]);
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pbpa_ctrl.sv
// pbpa_ctrl: request sequencer and output valid of the page allocator
// depends on pbpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbpa_ctrl
    import pbpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  req_t      req_type,
    output logic      out_valid,
    input  logic      out_ready,
    input  pbpa_sts_t sts,
    output pbpa_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req_type)
                        REQ_ALLOC_PAGE: state_next = sts.bad ? ST_DONE : ST_READ;
                        REQ_FREE_PAGE:  state_next = ST_READ;
                        REQ_ALLOC_NS:   state_next = ST_NS;
                        REQ_FREE_NS:    state_next = ST_NS;
                    endcase
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: state_next = sts.more ? ST_READ : ST_DONE;
            ST_NS:    state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.rd       = (state_reg == ST_READ);
        cmd.check    = (state_reg == ST_CHECK);
        cmd.ns_op    = (state_reg == ST_NS);
        cmd.out_load = (state_reg == ST_DONE) && out_free;
    end

    // output valid flag
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // one request in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while one is in flight");

    // a loaded result shows up as valid
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result load did not raise output valid");

    // finished scan always ends in the result state
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK && !sts.more) |=> (state_reg == ST_DONE))
        else $error("scan ended without a result");

    // result waits while the output register is still occupied
    a_result_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

endmodule

`default_nettype wire

>>> hw/rtl/pbpa_datapath.sv
// pbpa_datapath: used-page bitmap memory, scan logic, heads, namespace state,
// configuration registers and result registers; depends on pbpa_pkg
`timescale 1ns / 1ps
`default_nettype none

module pbpa_datapath
    import pbpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pbpa_cmd_t             cmd,
    output pbpa_sts_t             sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  req_t                  req_type,
    input  logic [PAGE_W-1:0]     page_index,
    input  logic [NS_W-1:0]       ns_index,
    output logic                  status,
    output logic [PAGE_W-1:0]     page_out,
    output logic [NS_W-1:0]       ns_out,
    output logic [PAGE_W-1:0]     ns_first_page,
    output logic [CNT_W-1:0]      ns_end_page
);

    localparam int PROD_W = NS_W + CNT_W;

    // configuration and persistent state
    logic                ns_enable_reg;
    logic [LOG2_W-1:0]   ns_log2_reg;
    logic [CNT_W-1:0]    pages_reg;
    logic [PAGE_W-1:0]   pool_next_reg;
    logic [PAGE_W-1:0]   ns_off_reg [NS_MAX];   // head offset inside its namespace
    logic [NS_MAX-1:0]   ns_busy_reg;
    logic [NS_W-1:0]     ns_rotor_reg;

    // request and scan registers
    req_t                req_reg;
    logic [NS_W-1:0]     nidx_reg;
    logic [CNT_W-1:0]    lo_reg;
    logic [CNT_W-1:0]    hi_reg;
    logic [CNT_W-1:0]    head_reg;
    logic [WADDR_W-1:0]  word_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                pass_reg;              // 0: [head, hi), 1: [lo, head)

    // bitmap memory
    word_t               mem [WORDS];
    logic [WORDS-1:0]    row_valid_reg;
    word_t               rdata_reg;
    logic                rvalid_reg;
    logic                mem_we;
    word_t               mem_wdata;

    // result registers
    logic                res_status_reg;
    logic [PAGE_W-1:0]   res_page_reg;
    logic [NS_W-1:0]     res_ns_reg;
    logic [PAGE_W-1:0]   res_first_reg;
    logic [CNT_W-1:0]    res_end_reg;
    logic                out_status_reg;
    logic [PAGE_W-1:0]   out_page_reg;
    logic [NS_W-1:0]     out_ns_reg;
    logic [PAGE_W-1:0]   out_first_reg;
    logic [CNT_W-1:0]    out_end_reg;

    // geometry
    logic [LOG2_W-1:0]   l_eff;
    logic [NS_W:0]       cnt;
    logic [NS_W-1:0]     cnt_m1;
    logic [CNT_W-1:0]    p_clamp;
    logic [CNT_W-1:0]    sz;
    logic [NS_MAX-1:0]   cnt_mask;

    // request setup
    logic [PROD_W-1:0]   in_lo_prod;
    logic [CNT_W-1:0]    in_lo;
    logic [CNT_W-1:0]    in_head;
    logic                ns_bad;
    logic                alloc_bad;

    // scan step
    word_t               cur;
    logic [CNT_W-1:0]    pass_lo;
    logic [CNT_W-1:0]    pass_hi;
    logic [CNT_W-1:0]    pass_hi_m1;
    word_t               cand;
    logic                hit;
    logic [BIT_W-1:0]    hit_pos;
    logic [PAGE_W-1:0]   found;
    logic [CNT_W-1:0]    found_next;
    logic                at_end;
    logic                scan_more;
    logic                alloc_more;

    // namespace step
    logic [NS_W-1:0]     r0;
    logic [NS_MAX-1:0]   avail;
    logic [2*NS_MAX-1:0] avail_dup;
    logic [NS_MAX-1:0]   rotated;
    logic                ns_got;
    logic [BIT_W-1:0]    ns_ffs;
    logic [NS_W-1:0]     ns_pick;
    logic [PROD_W-1:0]   ns_prod;

    // namespace geometry from the configuration
    always_comb
    begin
        l_eff    = (ns_log2_reg > LOG2_W'(NS_W)) ? LOG2_W'(NS_W) : ns_log2_reg;
        cnt      = (NS_W+1)'(1) << l_eff;
        cnt_m1   = NS_W'(cnt - (NS_W+1)'(1));
        p_clamp  = (pages_reg > CNT_W'(POOL_PAGES)) ? CNT_W'(POOL_PAGES) : pages_reg;
        sz       = p_clamp >> l_eff;
        cnt_mask = ~({NS_MAX{1'b1}} << cnt);
    end

    // bounds of the incoming request
    always_comb
    begin
        in_lo_prod = PROD_W'(ns_index) * PROD_W'(sz);
        in_lo      = CNT_W'(in_lo_prod);
        in_head    = in_lo + CNT_W'(ns_off_reg[ns_index]);
        ns_bad     = ((NS_W+1)'(ns_index) >= cnt) || (sz == '0);
        alloc_bad  = (req_type == REQ_ALLOC_PAGE) && ns_enable_reg && ns_bad;
    end

    // free-page search in the current word
    always_comb
    begin
        cur        = rvalid_reg ? rdata_reg : '0;
        pass_lo    = pass_reg ? lo_reg : head_reg;
        pass_hi    = pass_reg ? head_reg : hi_reg;
        pass_hi_m1 = pass_hi - CNT_W'(1);
        cand       = ~cur & mask_at_or_above(word_reg, pass_lo)
                          & mask_below(word_reg, pass_hi);
        hit        = |cand;
        hit_pos    = first_set(cand);
        found      = {word_reg, hit_pos};
        found_next = CNT_W'(found) + CNT_W'(1);
        at_end     = (word_reg == pass_hi_m1[PAGE_W-1:BIT_W]);
        scan_more  = !hit && (!at_end || (!pass_reg && (head_reg != lo_reg)));
        alloc_more = (req_reg == REQ_ALLOC_PAGE) && scan_more;
    end

    // status to the controller
    assign sts = '{bad: alloc_bad, more: alloc_more};

    // bitmap write: set the granted bit or clear the freed one
    always_comb
    begin
        mem_we    = cmd.check && ((req_reg == REQ_FREE_PAGE) ||
                                  ((req_reg == REQ_ALLOC_PAGE) && hit));
        if (req_reg == REQ_FREE_PAGE)
            mem_wdata = cur & ~(word_t'(1) << bit_reg);
        else
            mem_wdata = cur | (word_t'(1) << hit_pos);
    end

    // round-robin namespace pick starting at the rotor
    always_comb
    begin
        r0        = ns_rotor_reg & cnt_m1;
        avail     = ~ns_busy_reg & cnt_mask;
        avail_dup = {avail, avail} >> r0;
        rotated   = avail_dup[NS_MAX-1:0];
        ns_got    = |rotated;
        ns_ffs    = first_set(WORD_BITS'(rotated));
        ns_pick   = r0 + ns_ffs[NS_W-1:0];
        ns_prod   = PROD_W'(ns_pick) * PROD_W'(sz);
    end

    // configuration, heads, busy flags and rotor
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_enable_reg <= 1'b0;
            ns_log2_reg   <= '0;
            pages_reg     <= CNT_W'(POOL_PAGES);
            pool_next_reg <= '0;
            ns_busy_reg   <= '0;
            ns_rotor_reg  <= '0;
            for (int i = 0; i < NS_MAX; i++)
                ns_off_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NS_ENABLE:
                        ns_enable_reg <= cfg_data[0];
                    CFG_NS_COUNT_LOG2:
                    begin
                        ns_log2_reg <= cfg_data[LOG2_W-1:0];
                        for (int i = 0; i < NS_MAX; i++)
                            ns_off_reg[i] <= '0;
                    end
                    CFG_PAGES_IN_USE:
                    begin
                        pages_reg <= cfg_data[CNT_W-1:0];
                        for (int i = 0; i < NS_MAX; i++)
                            ns_off_reg[i] <= '0;
                    end
                    default: ;
                endcase
            end

            // advance the head past a granted page
            if (cmd.check && (req_reg == REQ_ALLOC_PAGE) && hit)
            begin
                if (ns_enable_reg)
                begin
                    if (found_next >= hi_reg)
                        ns_off_reg[nidx_reg] <= '0;
                    else
                        ns_off_reg[nidx_reg] <= PAGE_W'(found_next - lo_reg);
                end
                else
                begin
                    if (found_next >= CNT_W'(POOL_PAGES))
                        pool_next_reg <= '0;
                    else
                        pool_next_reg <= found_next[PAGE_W-1:0];
                end
            end

            if (cmd.ns_op)
            begin
                if (req_reg == REQ_ALLOC_NS)
                begin
                    if (ns_got)
                    begin
                        ns_busy_reg[ns_pick] <= 1'b1;
                        ns_rotor_reg         <= (ns_pick + NS_W'(1)) & cnt_m1;
                    end
                end
                else if ((NS_W+1)'(nidx_reg) < cnt)
                    ns_busy_reg[nidx_reg] <= 1'b0;
            end
        end
    end

    // request latch and scan position
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg  <= req_type;
            nidx_reg <= ns_index;
            bit_reg  <= page_index[BIT_W-1:0];
            pass_reg <= 1'b0;
            if (ns_enable_reg)
            begin
                lo_reg   <= in_lo;
                hi_reg   <= in_lo + sz;
                head_reg <= in_head;
            end
            else
            begin
                lo_reg   <= '0;
                hi_reg   <= CNT_W'(POOL_PAGES);
                head_reg <= CNT_W'(pool_next_reg);
            end
            // page_index always lies inside the pool, so a free needs no range check
            if (req_type == REQ_FREE_PAGE)
                word_reg <= page_index[PAGE_W-1:BIT_W];
            else if (ns_enable_reg)
                word_reg <= in_head[PAGE_W-1:BIT_W];
            else
                word_reg <= pool_next_reg[PAGE_W-1:BIT_W];
        end
        else if (cmd.check && scan_more)
        begin
            if (at_end)
            begin
                pass_reg <= 1'b1;
                word_reg <= lo_reg[PAGE_W-1:BIT_W];
            end
            else
                word_reg <= word_reg + WADDR_W'(1);
        end
    end

    // bitmap memory, one word read or written per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[word_reg] <= mem_wdata;
        if (cmd.rd)
        begin
            rdata_reg  <= mem[word_reg];
            rvalid_reg <= row_valid_reg[word_reg];
        end
    end

    // row valid bits: a row never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            row_valid_reg <= '0;
        else if (mem_we)
            row_valid_reg[word_reg] <= 1'b1;
    end

    // result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_status_reg <= alloc_bad;
            res_page_reg   <= '0;
            res_ns_reg     <= '0;
            res_first_reg  <= '0;
            res_end_reg    <= '0;
        end
        else if (cmd.check && (req_reg == REQ_ALLOC_PAGE))
        begin
            if (hit)
                res_page_reg <= found;
            else if (!scan_more)
                res_status_reg <= 1'b1;
        end
        else if (cmd.ns_op && (req_reg == REQ_ALLOC_NS))
        begin
            if (ns_got)
            begin
                res_ns_reg    <= ns_pick;
                res_first_reg <= ns_prod[PAGE_W-1:0];
                res_end_reg   <= CNT_W'(ns_prod + PROD_W'(sz));
            end
            else
                res_status_reg <= 1'b1;
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_page_reg   <= res_page_reg;
            out_ns_reg     <= res_ns_reg;
            out_first_reg  <= res_first_reg;
            out_end_reg    <= res_end_reg;
        end
    end

    assign status        = out_status_reg;
    assign page_out      = out_page_reg;
    assign ns_out        = out_ns_reg;
    assign ns_first_page = out_first_reg;
    assign ns_end_page   = out_end_reg;

endmodule

`default_nettype wire

>>> hw/rtl/partitioned_bitmap_page_allocator.sv
// partitioned_bitmap_page_allocator: top level of the bitmap page allocator
// depends on pbpa_pkg, pbpa_ctrl, pbpa_datapath
//
// Requests enter on the s_axis channel (tuser = request kind, tdata = page
// index and namespace index); every request gives exactly one result on the
// m_axis channel (tuser = status, tdata = granted page and namespace bounds).
// Configuration registers are written through cfg_we/cfg_index/cfg_data by the
// user only while no request is in flight; the block has no check for this.
// On the way from the input transfer to the output register, a page alloc with
// an empty or invalid namespace goes straight to the result state, namespace
// alloc and free take one namespace step, a page free reads and writes back
// its bitmap word, and a page alloc reads W bitmap words (W from 1 up to 33).
// Each word takes a registered memory read and then a check step; one request
// is handled at a time; the next is taken in the cycle after a result loads.
// The result sits in an output register, so a new request is taken while an
// earlier result waits; when the receiver stalls with the register full, the
// block holds its finished result and takes no further request.
// Reset clears the bitmap through per-row valid bits (no clearing pass), frees
// every namespace, points each namespace head at its first page, zeroes the
// pool head and the rotor, and restores the configuration registers.
`timescale 1ns / 1ps
`default_nettype none

module partitioned_bitmap_page_allocator
    import pbpa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // page_index, ns_index, zero pad
    input  logic [REQ_W-1:0]       s_axis_tuser,   // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // page_out, ns_out, ns_first_page,
                                                   // ns_end_page, zero pad
    output logic [0:0]             m_axis_tuser,   // status
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    pbpa_cmd_t          cmd;
    pbpa_sts_t          sts;
    req_t               req_type;
    logic [PAGE_W-1:0]  page_index;
    logic [NS_W-1:0]    ns_index;
    logic               status;
    logic [PAGE_W-1:0]  page_out;
    logic [NS_W-1:0]    ns_out;
    logic [PAGE_W-1:0]  ns_first_page;
    logic [CNT_W-1:0]   ns_end_page;

    // unpack the request transfer
    assign req_type   = req_t'(s_axis_tuser);
    assign page_index = s_axis_tdata[PAGE_W-1:0];
    assign ns_index   = s_axis_tdata[PAGE_W+NS_W-1:PAGE_W];

    pbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .req_type  (req_type),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pbpa_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_type      (req_type),
        .page_index    (page_index),
        .ns_index      (ns_index),
        .status        (status),
        .page_out      (page_out),
        .ns_out        (ns_out),
        .ns_first_page (ns_first_page),
        .ns_end_page   (ns_end_page)
    );

    // pack the result transfer
    assign m_axis_tdata = OUT_TDATA_W'({ns_end_page, ns_first_page, ns_out, page_out});
    assign m_axis_tuser = status;

endmodule

`default_nettype wire
